@@ rtl/wrs_pkg.sv @@
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared widths and constants for the Wilder RSI stream core.
// ----------------------------------------------------------------------------
package wrs_pkg;

  localparam int PRICE_IN_W = 32;   // width of the close_price field
  localparam int PRICE_BITS = 32;   // bits of the price actually used
  localparam int FRAC_BITS  = 16;   // fraction bits of the averages
  localparam int MAX_PERIOD = 64;
  localparam int PERIOD_W   = 7;
  localparam int COUNT_W    = 7;
  localparam int AVG_W      = 48;
  localparam int RSI_W      = 14;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = PERIOD_W'(2);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(MAX_PERIOD);
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
  localparam logic [RSI_W-1:0]    RSI_FULL     = RSI_W'(10000);
  localparam logic [AVG_W-1:0]    AVG_MAX      = '1;

endpackage

@@ rtl/wrs_in_if.sv @@
// ----------------------------------------------------------------------------
// wrs_in_if
// Price input channel: valid/ready handshake with close price and restart.
// ----------------------------------------------------------------------------
interface wrs_in_if;
  import wrs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PRICE_IN_W-1:0] close_price;
  logic                  new_series;

  modport source (output valid, close_price, new_series, input ready);
  modport sink   (input valid, close_price, new_series, output ready);
endinterface

@@ rtl/wrs_out_if.sv @@
// ----------------------------------------------------------------------------
// wrs_out_if
// Result channel: valid/ready handshake with RSI and smoothed averages.
// ----------------------------------------------------------------------------
interface wrs_out_if;
  import wrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [RSI_W-1:0] rsi_hundredths;
  logic             rsi_valid;
  logic [AVG_W-1:0] average_gain;
  logic [AVG_W-1:0] average_loss;

  modport source (output valid, rsi_hundredths, rsi_valid, average_gain, average_loss,
                  input ready);
  modport sink   (input valid, rsi_hundredths, rsi_valid, average_gain, average_loss,
                  output ready);
endinterface

@@ rtl/wilder_rsi_stream_core.sv @@
// ----------------------------------------------------------------------------
// wilder_rsi_stream_core
// Wilder RSI over a stream of closing prices, one result beat per price beat.
// ----------------------------------------------------------------------------
// Each price beat yields one result beat. A beat that starts a series (or the
// first after reset) goes from acceptance to ST_DONE, where it is loaded into the
// result register once that register is free. Any other beat runs through one
// shared multiplier and a restoring divider that retires one quotient bit per
// cycle: 48 steps each for the gain and loss averages and 14 steps for the RSI
// ratio, each division set up in ST_MUL, before ST_DONE loads the result. When
// the loss average is zero the RSI division is skipped and full scale is used.
// The input is not ready while a beat is in flight and comes back the cycle
// after the result is loaded; the result register lets the next price beat be
// taken while a finished result still waits downstream.
module wilder_rsi_stream_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [wrs_pkg::PERIOD_W-1:0]  cfg_wr_data,
  wrs_in_if.sink                        in_ch,
  wrs_out_if.source                     out_ch
);
  import wrs_pkg::*;

  localparam int NUM_W  = 64;
  localparam int REM_W  = AVG_W + 1;
  localparam int MULB_W = RSI_W;
  localparam int PROD_W = AVG_W + MULB_W;
  localparam int STEP_W = 6;
  localparam int STEPS_AVG = AVG_W;
  localparam int STEPS_RSI = RSI_W;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;
  typedef enum logic [1:0] {PH_GAIN, PH_LOSS, PH_RSI} phase_t;

  state_t                state_r;
  phase_t                phase_r;
  logic [PERIOD_W-1:0]   period_r;
  logic [PRICE_BITS-1:0] last_price_r;
  logic                  have_price_r;
  logic [COUNT_W-1:0]    count_r;
  logic [AVG_W-1:0]      gain_avg_r;
  logic [AVG_W-1:0]      loss_avg_r;
  logic [AVG_W-1:0]      gain_x_r;
  logic [AVG_W-1:0]      loss_x_r;
  logic [PERIOD_W-1:0]   div_d_r;
  logic                  res_valid_r;
  logic [RSI_W-1:0]      rsi_r;

  // shared divider
  logic [REM_W-1:0]      rem_r;
  logic [NUM_W-1:0]      num_r;
  logic [AVG_W-1:0]      quo_r;
  logic [REM_W-1:0]      den_r;
  logic [STEP_W-1:0]     step_r;

  // result register
  logic                  out_valid_r;
  logic [RSI_W-1:0]      out_rsi_r;
  logic                  out_rsi_valid_r;
  logic [AVG_W-1:0]      out_gain_r;
  logic [AVG_W-1:0]      out_loss_r;

  logic                  in_fire;
  logic [PRICE_BITS-1:0] price;
  logic [COUNT_W-1:0]    count_inc;
  logic [PERIOD_W-1:0]   period_eff;
  logic [PERIOD_W-1:0]   d_new;
  logic [PRICE_BITS-1:0] diff;
  logic [NUM_W-1:0]      diff_scaled;
  logic [AVG_W-1:0]      diff_sat;
  logic [AVG_W-1:0]      mul_a;
  logic [MULB_W-1:0]     mul_b;
  logic [PROD_W-1:0]     prod;
  logic [NUM_W-1:0]      numer;
  logic [REM_W:0]        trial;
  logic                  trial_ge;
  logic [REM_W-1:0]      rem_step;
  logic [AVG_W-1:0]      quo_fin;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign price       = PRICE_BITS'(in_ch.close_price);

  always_comb begin
    count_inc = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(1);
    if (period_r < PERIOD_MIN) begin
      period_eff = PERIOD_MIN;
    end else if (period_r > PERIOD_MAX) begin
      period_eff = PERIOD_MAX;
    end else begin
      period_eff = period_r;
    end
    d_new       = (PERIOD_W'(count_inc) < period_eff) ? PERIOD_W'(count_inc) : period_eff;
    diff        = (price > last_price_r) ? price - last_price_r : last_price_r - price;
    diff_scaled = NUM_W'(diff) << FRAC_BITS;
    diff_sat    = (diff_scaled > NUM_W'(AVG_MAX)) ? AVG_MAX : AVG_W'(diff_scaled);
  end

  // shared multiplier: avg*(d-1) + x for the averages, 10000*G for the ratio
  always_comb begin
    case (phase_r)
      PH_LOSS: mul_a = loss_avg_r;
      default: mul_a = gain_avg_r;
    endcase
    mul_b = (phase_r == PH_RSI) ? MULB_W'(RSI_FULL) : MULB_W'(div_d_r - PERIOD_W'(1));
    prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
    case (phase_r)
      PH_GAIN: numer = NUM_W'(prod) + NUM_W'(gain_x_r);
      PH_LOSS: numer = NUM_W'(prod) + NUM_W'(loss_x_r);
      default: numer = NUM_W'(prod);
    endcase
  end

  // one restoring step per cycle
  always_comb begin
    trial    = {rem_r, num_r[NUM_W-1]};
    trial_ge = (trial >= {1'b0, den_r});
    rem_step = trial_ge ? REM_W'(trial - {1'b0, den_r}) : REM_W'(trial);
    quo_fin  = {quo_r[AVG_W-2:0], trial_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_GAIN;
      period_r     <= PERIOD_RESET;
      last_price_r <= '0;
      have_price_r <= 1'b0;
      count_r      <= '0;
      gain_avg_r   <= '0;
      loss_avg_r   <= '0;
      out_valid_r  <= 1'b0;
      step_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      // in ST_DONE the result register is either reloaded or held
      if (out_ch.ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            last_price_r <= price;
            have_price_r <= 1'b1;
            if (in_ch.new_series || !have_price_r) begin
              count_r     <= '0;
              gain_avg_r  <= '0;
              loss_avg_r  <= '0;
              res_valid_r <= 1'b0;
              rsi_r       <= '0;
              state_r     <= ST_DONE;
            end else begin
              count_r     <= count_inc;
              div_d_r     <= d_new;
              gain_x_r    <= (price > last_price_r) ? diff_sat : '0;
              loss_x_r    <= (price > last_price_r) ? '0 : diff_sat;
              res_valid_r <= 1'b1;
              phase_r     <= PH_GAIN;
              state_r     <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (phase_r == PH_RSI) begin
            if (loss_avg_r == '0) begin
              rsi_r   <= RSI_FULL;
              state_r <= ST_DONE;
            end else begin
              rem_r   <= REM_W'(numer >> STEPS_RSI);
              num_r   <= numer << (NUM_W - STEPS_RSI);
              den_r   <= REM_W'(gain_avg_r) + REM_W'(loss_avg_r);
              step_r  <= STEP_W'(STEPS_RSI);
              state_r <= ST_DIV;
            end
          end else begin
            rem_r   <= REM_W'(numer >> STEPS_AVG);
            num_r   <= numer << (NUM_W - STEPS_AVG);
            den_r   <= REM_W'(div_d_r);
            step_r  <= STEP_W'(STEPS_AVG);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r  <= rem_step;
          num_r  <= num_r << 1;
          quo_r  <= quo_fin;
          step_r <= step_r - STEP_W'(1);
          if (step_r == STEP_W'(1)) begin
            case (phase_r)
              PH_GAIN: begin
                gain_avg_r <= quo_fin;
                phase_r    <= PH_LOSS;
                state_r    <= ST_MUL;
              end
              PH_LOSS: begin
                loss_avg_r <= quo_fin;
                phase_r    <= PH_RSI;
                state_r    <= ST_MUL;
              end
              default: begin
                rsi_r   <= quo_fin[RSI_W-1:0];
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r     <= 1'b1;
            out_rsi_r       <= rsi_r;
            out_rsi_valid_r <= res_valid_r;
            out_gain_r      <= gain_avg_r;
            out_loss_r      <= loss_avg_r;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.rsi_hundredths = out_rsi_r;
  assign out_ch.rsi_valid      = out_rsi_valid_r;
  assign out_ch.average_gain   = out_gain_r;
  assign out_ch.average_loss   = out_loss_r;

  // partial remainder must stay below the divisor while dividing
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_no_change_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.rsi_valid) |->
      (out_ch.rsi_hundredths == '0 && out_ch.average_gain == '0 &&
       out_ch.average_loss == '0))
    else $error("result without a change carries nonzero fields");

  a_zero_loss_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.rsi_valid && out_ch.average_loss == '0) |->
      (out_ch.rsi_hundredths == RSI_FULL))
    else $error("zero loss average must give full scale RSI");

  a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.rsi_hundredths <= RSI_FULL))
    else $error("RSI above full scale");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r != STEP_W'(1)) |=> !in_ch.ready)
    else $error("input ready while a division is in flight");

endmodule
